// ----- rtl/core/fnfs_pkg.sv -----
package fnfs_pkg;

   // Default build values
   localparam int MAX_VECTOR_DEF  = 4096;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int PHASE_BITS_DEF  = 32;
   localparam int TABLE_DEPTH_DEF = 1024;

   // Fixed field and register widths
   localparam int SENS_W     = 32;
   localparam int VLEN_W     = 13;
   localparam int CP_W       = 13;
   localparam int OFFSET_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SENSITIVITY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CP_LENGTH     = 2'd2;

   localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd64;

   // Q4.12 offset: step = (sensitivity * offset) >> 12
   localparam int STEP_SHIFT = 12;

   // Sine table: unsigned Q0.15 magnitudes, signed coefficients one bit wider
   localparam int TAB_W       = 15;
   localparam int COEF_W      = 16;
   localparam int ROUND_SHIFT = 15;
   localparam int TAB_MAX     = 32767;

   // Front/back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Table generation, evaluated at elaboration only
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam longint unsigned ONE_Q30 = 64'd1 << 30;
   localparam longint unsigned TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

   // x is the Q2.30 angle; nested Taylor form of sin(x) scaled to Q0.15
   function automatic logic [TAB_W-1:0] sine_entry(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned e;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int n = 0; n < 5; n++) begin
         t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[n]);
      end
      s = (x * t) >> 30;
      e = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (e > longint'(TAB_MAX)) begin
         e = longint'(TAB_MAX);
      end
      return e[TAB_W-1:0];
   endfunction

endpackage

// ----- rtl/core/fnfs_queue.sv -----
module fnfs_queue #(
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0]                  entries_ff [fnfs_pkg::QUEUE_DEPTH];
   logic [fnfs_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [fnfs_pkg::QUEUE_PTR_W-1:0]  wr_ptr_in;
   logic [fnfs_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [fnfs_pkg::QUEUE_PTR_W-1:0]  rd_ptr_in;
   logic [fnfs_pkg::QUEUE_CNT_W-1:0]  count_ff;
   logic [fnfs_pkg::QUEUE_CNT_W-1:0]  count_in;
   logic                              do_push;
   logic                              do_pop;

   always_comb begin
      full      = count_ff == fnfs_pkg::QUEUE_CNT_W'(fnfs_pkg::QUEUE_DEPTH);
      pop_valid = count_ff != '0;
      pop_data  = entries_ff[rd_ptr_ff];
      do_push   = push_valid && !full;
      do_pop    = pop && pop_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/fnfs_front.sv -----
module fnfs_front #(
   parameter int MAX_VECTOR  = fnfs_pkg::MAX_VECTOR_DEF,
   parameter int SAMPLE_BITS = fnfs_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = fnfs_pkg::PHASE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fnfs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fnfs_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_im,
   input  logic                                req_frame_start,
   input  logic signed [fnfs_pkg::OFFSET_W-1:0] req_freq_offset,
   input  logic                                q_full,
   output logic                                push_valid,
   output logic signed [SAMPLE_BITS-1:0]       push_re,
   output logic signed [SAMPLE_BITS-1:0]       push_im,
   output logic [PHASE_BITS-1:0]               push_phase,
   output logic                                push_last
);

   localparam int IDX_W  = $clog2(MAX_VECTOR);
   localparam int LEN_W  = $clog2(MAX_VECTOR + 1);
   localparam int CMP_W  = (LEN_W > fnfs_pkg::VLEN_W) ? LEN_W : fnfs_pkg::VLEN_W;
   localparam int PROD_W = fnfs_pkg::SENS_W + fnfs_pkg::OFFSET_W + 1;
   localparam int EXT_W  = (PROD_W > PHASE_BITS + fnfs_pkg::STEP_SHIFT) ?
                           PROD_W : PHASE_BITS + fnfs_pkg::STEP_SHIFT;
   localparam int PFX_W  = PHASE_BITS + fnfs_pkg::CP_W;

   // run: one word/cycle unless stalled; prefix/issue: frame start; recalc: cp write
   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_PREFIX = 2'd1;
   localparam logic [1:0] ST_ISSUE  = 2'd2;
   localparam logic [1:0] ST_RECALC = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [fnfs_pkg::SENS_W-1:0]    sens_ff, sens_in;
   logic [fnfs_pkg::VLEN_W-1:0]    vlen_ff, vlen_in;
   logic [fnfs_pkg::CP_W-1:0]      cp_ff, cp_in;
   logic [PHASE_BITS-1:0]          phase_ff, phase_in;
   logic [PHASE_BITS-1:0]          step_ff, step_in;
   logic [PHASE_BITS-1:0]          prefix_ff, prefix_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   logic signed [SAMPLE_BITS-1:0]  hold_re_ff, hold_re_in;
   logic signed [SAMPLE_BITS-1:0]  hold_im_ff, hold_im_in;

   logic                           csr_write;
   logic                           accept;
   logic                           issue;
   logic [PHASE_BITS-1:0]          base_phase;
   logic [PHASE_BITS-1:0]          use_phase;
   logic [IDX_W-1:0]               cur_idx;
   logic [CMP_W-1:0]               vlen_ext;
   logic [CMP_W-1:0]               len_m1;
   logic signed [PROD_W-1:0]       step_prod;
   logic signed [EXT_W-1:0]        step_wide;
   logic [PFX_W-1:0]               prefix_prod;

   assign step_prod   = $signed({1'b0, sens_ff}) * req_freq_offset;
   assign step_wide   = EXT_W'(step_prod);
   assign prefix_prod = {{PHASE_BITS{1'b0}}, cp_ff} * {{fnfs_pkg::CP_W{1'b0}}, step_ff};

   always_comb begin
      csr_ready  = state_ff == ST_RUN;
      req_ready  = (state_ff == ST_RUN) && !csr_valid && !q_full;
      csr_write  = csr_valid && csr_ready;
      accept     = req_valid && req_ready;
      issue      = state_ff == ST_ISSUE;

      // frame start restarts both phase and vector count
      base_phase = issue ? '0 : phase_ff;
      cur_idx    = issue ? '0 : idx_ff;
      use_phase  = (cur_idx == '0) ? base_phase + prefix_ff : base_phase;

      vlen_ext = CMP_W'(vlen_ff);
      if (vlen_ext < CMP_W'(2)) begin
         len_m1 = CMP_W'(1);
      end else if (vlen_ext > CMP_W'(MAX_VECTOR)) begin
         len_m1 = CMP_W'(MAX_VECTOR - 1);
      end else begin
         len_m1 = vlen_ext - CMP_W'(1);
      end
      push_last  = CMP_W'(cur_idx) >= len_m1;

      push_valid = (accept && !req_frame_start) || (issue && !q_full);
      push_re    = issue ? hold_re_ff : req_sample_re;
      push_im    = issue ? hold_im_ff : req_sample_im;
      push_phase = use_phase;

      state_in   = state_ff;
      sens_in    = sens_ff;
      vlen_in    = vlen_ff;
      cp_in      = cp_ff;
      phase_in   = phase_ff;
      step_in    = step_ff;
      prefix_in  = prefix_ff;
      idx_in     = idx_ff;
      hold_re_in = hold_re_ff;
      hold_im_in = hold_im_ff;

      if (csr_write) begin
         case (csr_index)
            fnfs_pkg::CSR_SENSITIVITY: begin
               sens_in = csr_data;
            end
            fnfs_pkg::CSR_VECTOR_LENGTH: begin
               vlen_in = csr_data[fnfs_pkg::VLEN_W-1:0];
            end
            fnfs_pkg::CSR_CP_LENGTH: begin
               cp_in    = csr_data[fnfs_pkg::CP_W-1:0];
               state_in = ST_RECALC;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_RUN: begin
            if (accept && req_frame_start) begin
               step_in    = step_wide[PHASE_BITS+fnfs_pkg::STEP_SHIFT-1:fnfs_pkg::STEP_SHIFT];
               hold_re_in = req_sample_re;
               hold_im_in = req_sample_im;
               state_in   = ST_PREFIX;
            end
         end
         ST_PREFIX: begin
            prefix_in = prefix_prod[PHASE_BITS-1:0];
            state_in  = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (!q_full) begin
               state_in = ST_RUN;
            end
         end
         ST_RECALC: begin
            prefix_in = prefix_prod[PHASE_BITS-1:0];
            state_in  = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (push_valid) begin
         phase_in = use_phase + step_ff;
         idx_in   = push_last ? '0 : cur_idx + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         sens_ff   <= '0;
         vlen_ff   <= fnfs_pkg::VLEN_RESET;
         cp_ff     <= '0;
         phase_ff  <= '0;
         step_ff   <= '0;
         prefix_ff <= '0;
         idx_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         sens_ff   <= sens_in;
         vlen_ff   <= vlen_in;
         cp_ff     <= cp_in;
         phase_ff  <= phase_in;
         step_ff   <= step_in;
         prefix_ff <= prefix_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_re_ff <= hold_re_in;
      hold_im_ff <= hold_im_in;
   end

endmodule

// ----- rtl/core/fnfs_back.sv -----
module fnfs_back #(
   parameter int SAMPLE_BITS = fnfs_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = fnfs_pkg::PHASE_BITS_DEF,
   parameter int TABLE_DEPTH = fnfs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic signed [SAMPLE_BITS-1:0] q_re,
   input  logic signed [SAMPLE_BITS-1:0] q_im,
   input  logic [PHASE_BITS-1:0]         q_phase,
   input  logic                          q_last,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_re,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_im,
   output logic                          rsp_vector_end
);

   localparam int TI_W   = $clog2(TABLE_DEPTH + 1);
   localparam int REST_W = PHASE_BITS - 2;
   localparam int SC_W   = REST_W + TI_W;
   localparam int PW     = SAMPLE_BITS + fnfs_pkg::COEF_W;
   localparam int SW     = PW + 1;
   localparam int QW     = SW - fnfs_pkg::ROUND_SHIFT;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic signed [SW-1:0] RND_HALF = SW'(1) <<< (fnfs_pkg::ROUND_SHIFT - 1);
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // quarter-wave sine ROM, Q0.15 magnitudes
   logic [fnfs_pkg::TAB_W-1:0] rom_w [0:TABLE_DEPTH];

   for (genvar k = 0; k <= TABLE_DEPTH; k++) begin : g_rom
      localparam longint unsigned ANGLE =
         (fnfs_pkg::PI_Q30 * longint'(k)) / (2 * TABLE_DEPTH);
      assign rom_w[k] = fnfs_pkg::sine_entry(ANGLE);
   end

   logic                          adv;
   logic [SC_W-1:0]               scaled;
   logic [TI_W-1:0]               tab_idx;

   // stage 1: table read
   logic                          s1_valid_ff;
   logic [fnfs_pkg::TAB_W-1:0]    lo_ff;
   logic [fnfs_pkg::TAB_W-1:0]    hi_ff;
   logic [1:0]                    quad_ff;
   logic signed [SAMPLE_BITS-1:0] re1_ff;
   logic signed [SAMPLE_BITS-1:0] im1_ff;
   logic                          last1_ff;

   // stage 2: products
   logic signed [fnfs_pkg::COEF_W-1:0] lo_s;
   logic signed [fnfs_pkg::COEF_W-1:0] hi_s;
   logic signed [fnfs_pkg::COEF_W-1:0] cos_c;
   logic signed [fnfs_pkg::COEF_W-1:0] sin_c;
   logic                          s2_valid_ff;
   logic signed [PW-1:0]          p_rc_ff;
   logic signed [PW-1:0]          p_is_ff;
   logic signed [PW-1:0]          p_rs_ff;
   logic signed [PW-1:0]          p_ic_ff;
   logic                          last2_ff;

   // stage 3: round, saturate, output register
   logic signed [SW-1:0]          sum_a;
   logic signed [SW-1:0]          sum_b;
   logic signed [QW-1:0]          q_a;
   logic signed [QW-1:0]          q_b;
   logic signed [SAMPLE_BITS-1:0] sat_a;
   logic signed [SAMPLE_BITS-1:0] sat_b;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_re_ff;
   logic signed [SAMPLE_BITS-1:0] out_im_ff;
   logic                          out_last_ff;

   // whole pipe moves together; it freezes only when the output word is held
   assign adv   = !out_valid_ff || rsp_ready;
   assign q_pop = adv && q_valid;

   assign scaled  = {{TI_W{1'b0}}, q_phase[REST_W-1:0]} * SC_W'(TABLE_DEPTH);
   assign tab_idx = scaled[SC_W-1:REST_W];

   always_comb begin
      lo_s = $signed({1'b0, lo_ff});
      hi_s = $signed({1'b0, hi_ff});
      case (quad_ff)
         QUAD_0: begin
            cos_c = hi_s;
            sin_c = lo_s;
         end
         QUAD_1: begin
            cos_c = -lo_s;
            sin_c = hi_s;
         end
         QUAD_2: begin
            cos_c = -hi_s;
            sin_c = -lo_s;
         end
         QUAD_3: begin
            cos_c = lo_s;
            sin_c = -hi_s;
         end
         default: begin
            cos_c = hi_s;
            sin_c = lo_s;
         end
      endcase
   end

   always_comb begin
      sum_a = SW'(p_rc_ff) - SW'(p_is_ff) + RND_HALF;
      sum_b = SW'(p_rs_ff) + SW'(p_ic_ff) + RND_HALF;
      q_a   = sum_a[SW-1:fnfs_pkg::ROUND_SHIFT];
      q_b   = sum_b[SW-1:fnfs_pkg::ROUND_SHIFT];
      if (q_a[QW-1:SAMPLE_BITS-1] == '0 || q_a[QW-1:SAMPLE_BITS-1] == '1) begin
         sat_a = q_a[SAMPLE_BITS-1:0];
      end else begin
         sat_a = q_a[QW-1] ? SAT_MIN : SAT_MAX;
      end
      if (q_b[QW-1:SAMPLE_BITS-1] == '0 || q_b[QW-1:SAMPLE_BITS-1] == '1) begin
         sat_b = q_b[SAMPLE_BITS-1:0];
      end else begin
         sat_b = q_b[QW-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff       <= rom_w[tab_idx];
         hi_ff       <= rom_w[TI_W'(TABLE_DEPTH) - tab_idx];
         quad_ff     <= q_phase[PHASE_BITS-1:REST_W];
         re1_ff      <= q_re;
         im1_ff      <= q_im;
         last1_ff    <= q_last;
         p_rc_ff     <= re1_ff * cos_c;
         p_is_ff     <= im1_ff * sin_c;
         p_rs_ff     <= re1_ff * sin_c;
         p_ic_ff     <= im1_ff * cos_c;
         last2_ff    <= last1_ff;
         out_re_ff   <= sat_a;
         out_im_ff   <= sat_b;
         out_last_ff <= last2_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_re     = out_re_ff;
   assign rsp_out_im     = out_im_ff;
   assign rsp_vector_end = out_last_ff;

endmodule

// ----- rtl/core/frame_synced_nco_frequency_shifter.sv -----
// Frame-synced NCO frequency shifter: mixes each complex sample by exp(+j*phase).
// req_*  : one sample word per handshake (valid/ready). req_frame_start marks the
//          first sample of a frame; req_freq_offset (Q4.12) is taken only then.
// rsp_*  : one shifted sample word per request, in order; rsp_vector_end flags
//          the last sample of each vector.
// csr_*  : register writes (0 sensitivity, 1 vector_length, 2 prefix length),
//          other indexes are ignored. The user must write them only while no word
//          is in flight; the block itself does not enforce this.
// Throughput: 1 word per cycle for ordinary samples while the queue has room and
//          no csr write waits; a frame-start word holds the request side through
//          the prefix and issue states, set by the two chained multipliers in the
//          front end (step multiply, then prefix multiply). A prefix length write
//          holds it through the recalc state for the same prefix multiply.
// Stall: a 4-word queue sits between the phase front end and the mixer pipe.
//          When rsp_ready is low the mixer pipe freezes, the queue fills, and
//          req_ready drops once it is full; no word is lost or repeated.
// Reset: synchronous, active high. Clears phase, step, prefix advance and sample
//          count; sensitivity 0, vector_length 64, prefix length 0.
module frame_synced_nco_frequency_shifter #(
   parameter int MAX_VECTOR  = fnfs_pkg::MAX_VECTOR_DEF,
   parameter int SAMPLE_BITS = fnfs_pkg::SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = fnfs_pkg::PHASE_BITS_DEF,
   parameter int TABLE_DEPTH = fnfs_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fnfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fnfs_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_re,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample_im,
   input  logic                                 req_frame_start,
   input  logic signed [fnfs_pkg::OFFSET_W-1:0] req_freq_offset,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_re,
   output logic signed [SAMPLE_BITS-1:0]        rsp_out_im,
   output logic                                 rsp_vector_end
);

   // queue word: {last, phase, im, re}
   localparam int QW_W = 2 * SAMPLE_BITS + PHASE_BITS + 1;

   logic                          push_valid;
   logic signed [SAMPLE_BITS-1:0] push_re;
   logic signed [SAMPLE_BITS-1:0] push_im;
   logic [PHASE_BITS-1:0]         push_phase;
   logic                          push_last;
   logic                          q_full;
   logic                          q_pop;
   logic                          q_valid;
   logic [QW_W-1:0]               q_push_data;
   logic [QW_W-1:0]               q_pop_data;

   // front: config registers, phase accumulator, vector count
   fnfs_front #(
      .MAX_VECTOR  (MAX_VECTOR),
      .SAMPLE_BITS (SAMPLE_BITS),
      .PHASE_BITS  (PHASE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .req_frame_start (req_frame_start),
      .req_freq_offset (req_freq_offset),
      .q_full          (q_full),
      .push_valid      (push_valid),
      .push_re         (push_re),
      .push_im         (push_im),
      .push_phase      (push_phase),
      .push_last       (push_last)
   );

   assign q_push_data = {push_last, push_phase, push_im, push_re};

   fnfs_queue #(
      .WIDTH (QW_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (q_push_data),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_pop_data)
   );

   // back: sine lookup, complex multiply, round and saturate
   fnfs_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .PHASE_BITS  (PHASE_BITS),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_re           (q_pop_data[SAMPLE_BITS-1:0]),
      .q_im           (q_pop_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .q_phase        (q_pop_data[2*SAMPLE_BITS+PHASE_BITS-1:2*SAMPLE_BITS]),
      .q_last         (q_pop_data[QW_W-1]),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_re     (rsp_out_re),
      .rsp_out_im     (rsp_out_im),
      .rsp_vector_end (rsp_vector_end)
   );

endmodule
